FILE: src/ledfs_pkg.sv
// Shared constants, types and helper functions for the LED driver frame sender.
package ledfs_pkg;

  // Channel counts: CHANNELS sets the frame size, PORT_CH is the number of level ports
  // and current registers that the block actually has.
  localparam int CHANNELS  = 5;
  localparam int PORT_CH   = 5;
  localparam int FRAME_MAX = 1 + 2 * CHANNELS;
  localparam int IDX_W     = $clog2(FRAME_MAX);
  localparam int LEN_W     = $clog2(FRAME_MAX + 1);

  // Command bytes that open a frame.
  localparam logic [7:0] CMD_CURRENT = 8'h40;
  localparam logic [7:0] CMD_LEVEL   = 8'h66;

  // Current coding limits in mA.
  localparam logic [7:0] MA_MIN    = 8'd5;
  localparam logic [7:0] MA_MAX    = 8'd60;
  localparam logic [7:0] MA_OFFSET = 8'd4;

  // Input opcodes.
  localparam logic [1:0] OP_TICK         = 2'd0;
  localparam logic [1:0] OP_SEND_CURRENT = 2'd1;
  localparam logic [1:0] OP_SEND_LEVEL   = 2'd2;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_RED_CURRENT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_CURRENT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_CURRENT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLD_CURRENT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WARM_CURRENT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ACK_TIMEOUT   = 3'd5;

  // Register reset values.
  localparam logic [7:0]  RGB_CURRENT_RST   = 8'd10;
  localparam logic [7:0]  WHITE_CURRENT_RST = 8'd20;
  localparam logic [15:0] ACK_TIMEOUT_RST   = 16'd125;

  // Classified input item.
  typedef enum logic [1:0] {
    KIND_TICK,
    KIND_SEND,
    KIND_IGNORE
  } kind_t;

  typedef struct packed {
    kind_t                     kind;
    logic [FRAME_MAX-1:0][7:0] bytes;
    logic [LEN_W-1:0]          length;
    logic                      sda_in;
  } item_t;

  typedef struct packed {
    logic scl;
    logic sda;
    logic busy;
    logic done;
    logic ok;
    logic online;
  } result_t;

  // Clamp a current to the legal range and code it as (mA - 4) / 2.
  function automatic logic [7:0] code_current(input logic [7:0] ma);
    logic [7:0] c;
    logic [7:0] d;
    c = ma;
    if (c < MA_MIN) c = MA_MIN;
    if (c > MA_MAX) c = MA_MAX;
    d = c - MA_OFFSET;
    return {1'b0, d[7:1]};
  endfunction

endpackage

FILE: src/ledfs_front.sv
// Front end: configuration registers, item classification, frame build and the item queue.
module ledfs_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic [1:0]                        opcode,
  input  logic [7:0]                        red_level,
  input  logic [7:0]                        green_level,
  input  logic [7:0]                        blue_level,
  input  logic [7:0]                        cold_white_level,
  input  logic [7:0]                        warm_white_level,
  input  logic                              sda_in,
  input  logic                              cfg_write,
  input  logic [ledfs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ledfs_pkg::CFG_DAT_W-1:0]   cfg_data,
  output logic [15:0]                       ack_timeout,
  output logic                              item_valid,
  input  logic                              item_ready,
  output ledfs_pkg::item_t                  item
);

  logic [7:0]        cur_ma   [ledfs_pkg::PORT_CH];
  logic [7:0]        port_lvl [ledfs_pkg::PORT_CH];
  logic [7:0]        lvl      [ledfs_pkg::CHANNELS];
  logic [7:0]        code     [ledfs_pkg::CHANNELS];
  ledfs_pkg::item_t  new_item;
  ledfs_pkg::item_t  q [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;
  logic              push_ok;
  logic              pop_ok;

  // Configuration registers; writes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_ma[0]   <= ledfs_pkg::RGB_CURRENT_RST;
      cur_ma[1]   <= ledfs_pkg::RGB_CURRENT_RST;
      cur_ma[2]   <= ledfs_pkg::RGB_CURRENT_RST;
      cur_ma[3]   <= ledfs_pkg::WHITE_CURRENT_RST;
      cur_ma[4]   <= ledfs_pkg::WHITE_CURRENT_RST;
      ack_timeout <= ledfs_pkg::ACK_TIMEOUT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        ledfs_pkg::REG_RED_CURRENT:   cur_ma[0]   <= cfg_data[7:0];
        ledfs_pkg::REG_GREEN_CURRENT: cur_ma[1]   <= cfg_data[7:0];
        ledfs_pkg::REG_BLUE_CURRENT:  cur_ma[2]   <= cfg_data[7:0];
        ledfs_pkg::REG_COLD_CURRENT:  cur_ma[3]   <= cfg_data[7:0];
        ledfs_pkg::REG_WARM_CURRENT:  cur_ma[4]   <= cfg_data[7:0];
        ledfs_pkg::REG_ACK_TIMEOUT:   ack_timeout <= cfg_data;
        default: ;
      endcase
    end
  end

  assign port_lvl[0] = red_level;
  assign port_lvl[1] = green_level;
  assign port_lvl[2] = blue_level;
  assign port_lvl[3] = cold_white_level;
  assign port_lvl[4] = warm_white_level;

  // Per-channel level and current code; channels without a port read as zero.
  for (genvar g = 0; g < ledfs_pkg::CHANNELS; g++) begin : g_ch
    if (g < ledfs_pkg::PORT_CH) begin : g_port
      assign lvl[g]  = port_lvl[g];
      assign code[g] = ledfs_pkg::code_current(cur_ma[g]);
    end else begin : g_zero
      assign lvl[g]  = '0;
      assign code[g] = ledfs_pkg::code_current(8'd0);
    end
  end

  // Classify the incoming beat and build the frame it would send.
  always_comb begin
    new_item        = '0;
    new_item.sda_in = sda_in;
    case (opcode)
      ledfs_pkg::OP_TICK: begin
        new_item.kind = ledfs_pkg::KIND_TICK;
      end
      ledfs_pkg::OP_SEND_CURRENT: begin
        new_item.kind     = ledfs_pkg::KIND_SEND;
        new_item.bytes[0] = ledfs_pkg::CMD_CURRENT;
        for (int i = 0; i < ledfs_pkg::CHANNELS; i++) begin
          new_item.bytes[1 + i] = code[i];
        end
        new_item.length = ledfs_pkg::LEN_W'(1 + ledfs_pkg::CHANNELS);
      end
      ledfs_pkg::OP_SEND_LEVEL: begin
        new_item.kind     = ledfs_pkg::KIND_SEND;
        new_item.bytes[0] = ledfs_pkg::CMD_LEVEL;
        for (int i = 0; i < ledfs_pkg::CHANNELS; i++) begin
          new_item.bytes[1 + 2 * i] = {6'd0, lvl[i][7:6]};
          new_item.bytes[2 + 2 * i] = {lvl[i][5:0], 2'b00};
        end
        new_item.length = ledfs_pkg::LEN_W'(ledfs_pkg::FRAME_MAX);
      end
      default: begin
        new_item.kind = ledfs_pkg::KIND_IGNORE;
      end
    endcase
  end

  // Two-entry queue toward the bus engine.
  assign full       = (count == 2'd2);
  assign item_valid = (count != 2'd0);
  assign item       = q[rd_ptr];
  assign push_ok    = push && !full;
  assign pop_ok     = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q[wr_ptr] <= new_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push_ok) wr_ptr <= !wr_ptr;
      if (pop_ok)  rd_ptr <= !rd_ptr;
      case ({push_ok, pop_ok})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: src/ledfs_back.sv
// Back end: bus phase sequencer, frame byte store and the result queue.
module ledfs_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [15:0]          ack_timeout,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  ledfs_pkg::item_t     item,
  output logic                 empty,
  input  logic                 pop,
  output ledfs_pkg::result_t   result
);

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_START1,
    PH_START2,
    PH_BIT_LOW,
    PH_BIT_HIGH,
    PH_ACK_REL,
    PH_ACK_POLL,
    PH_ACK_END,
    PH_STOP1,
    PH_STOP2
  } phase_t;

  phase_t                               phase;
  phase_t                               phase_next;
  logic [ledfs_pkg::FRAME_MAX-1:0][7:0] frame_bytes;
  logic [ledfs_pkg::IDX_W-1:0]          byte_index;
  logic [ledfs_pkg::IDX_W-1:0]          byte_index_next;
  logic [ledfs_pkg::LEN_W-1:0]          frame_length;
  logic [2:0]                           bit_index;
  logic [2:0]                           bit_index_next;
  logic [15:0]                          ack_timer;
  logic [15:0]                          ack_timer_next;
  logic [15:0]                          timer_inc;
  logic                                 abort_flag;
  logic                                 abort_next;
  logic                                 online_flag;
  logic                                 online_next;
  logic                                 load;
  logic                                 step;
  logic [7:0]                           cur_byte;
  logic                                 data_bit;
  logic                                 res_done;
  logic                                 res_ok;
  ledfs_pkg::result_t                   res;
  ledfs_pkg::result_t                   q [2];
  logic                                 wr_ptr;
  logic                                 rd_ptr;
  logic [1:0]                           count;
  logic                                 out_full;
  logic                                 pop_ok;

  assign out_full   = (count == 2'd2);
  assign item_ready = !out_full;
  assign step       = item_valid && !out_full;
  assign load       = (phase == PH_IDLE) && (item.kind == ledfs_pkg::KIND_SEND);
  assign timer_inc  = (ack_timer != 16'hFFFF) ? ack_timer + 16'd1 : ack_timer;

  // Next phase and counters for one beat.
  always_comb begin
    phase_next      = phase;
    byte_index_next = byte_index;
    bit_index_next  = bit_index;
    ack_timer_next  = ack_timer;
    abort_next      = abort_flag;
    online_next     = online_flag;
    res_done        = 1'b0;
    res_ok          = 1'b0;
    if (phase == PH_IDLE) begin
      if (load) begin
        byte_index_next = '0;
        bit_index_next  = '0;
        ack_timer_next  = '0;
        abort_next      = 1'b0;
        phase_next      = PH_START1;
      end
    end else if (item.kind == ledfs_pkg::KIND_TICK) begin
      case (phase)
        PH_START1:  phase_next = PH_START2;
        PH_START2:  phase_next = PH_BIT_LOW;
        PH_BIT_LOW: phase_next = PH_BIT_HIGH;
        PH_BIT_HIGH: begin
          if (bit_index != 3'd7) begin
            bit_index_next = bit_index + 3'd1;
            phase_next     = PH_BIT_LOW;
          end else begin
            phase_next = PH_ACK_REL;
          end
        end
        PH_ACK_REL: begin
          ack_timer_next = '0;
          phase_next     = PH_ACK_POLL;
        end
        PH_ACK_POLL: begin
          if (!item.sda_in) begin
            phase_next = PH_ACK_END;
          end else begin
            ack_timer_next = timer_inc;
            if (timer_inc >= ack_timeout) begin
              abort_next = 1'b1;
              phase_next = PH_ACK_END;
            end
          end
        end
        PH_ACK_END: begin
          if (!abort_flag &&
              (ledfs_pkg::LEN_W'(byte_index) + ledfs_pkg::LEN_W'(1)) < frame_length) begin
            byte_index_next = byte_index + ledfs_pkg::IDX_W'(1);
            bit_index_next  = '0;
            phase_next      = PH_BIT_LOW;
          end else begin
            phase_next = PH_STOP1;
          end
        end
        PH_STOP1: phase_next = PH_STOP2;
        PH_STOP2: begin
          res_done    = 1'b1;
          res_ok      = !abort_flag;
          online_next = !abort_flag;
          phase_next  = PH_IDLE;
        end
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  // Line drive for the phase reached by this beat.
  assign cur_byte = frame_bytes[byte_index_next];
  assign data_bit = cur_byte[3'd7 - bit_index_next];

  always_comb begin
    res.scl    = 1'b0;
    res.sda    = 1'b0;
    res.busy   = (phase_next != PH_IDLE);
    res.done   = res_done;
    res.ok     = res_ok;
    res.online = online_next;
    case (phase_next)
      PH_START1:   begin res.scl = 1'b0; res.sda = 1'b1;      end
      PH_START2:   begin res.scl = 1'b1; res.sda = 1'b1;      end
      PH_BIT_LOW:  begin res.scl = 1'b1; res.sda = !data_bit; end
      PH_BIT_HIGH: begin res.scl = 1'b0; res.sda = !data_bit; end
      PH_ACK_REL:  begin res.scl = 1'b1; res.sda = 1'b0;      end
      PH_ACK_POLL: begin res.scl = 1'b0; res.sda = 1'b0;      end
      PH_ACK_END:  begin res.scl = 1'b1; res.sda = 1'b0;      end
      PH_STOP1:    begin res.scl = 1'b1; res.sda = 1'b1;      end
      PH_STOP2:    begin res.scl = 1'b0; res.sda = 1'b1;      end
      default:     begin res.scl = 1'b0; res.sda = 1'b0;      end
    endcase
  end

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      byte_index   <= '0;
      frame_length <= '0;
      bit_index    <= '0;
      ack_timer    <= '0;
      abort_flag   <= 1'b0;
      online_flag  <= 1'b0;
    end else if (step) begin
      phase       <= phase_next;
      byte_index  <= byte_index_next;
      bit_index   <= bit_index_next;
      ack_timer   <= ack_timer_next;
      abort_flag  <= abort_next;
      online_flag <= online_next;
      if (load) frame_length <= item.length;
    end
  end

  // Frame byte store, loaded whole when a frame starts.
  always_ff @(posedge clk) begin
    if (step && load) begin
      frame_bytes <= item.bytes;
    end
  end

  // Two-entry result queue.
  assign empty  = (count == 2'd0);
  assign result = q[rd_ptr];
  assign pop_ok = pop && !empty;

  always_ff @(posedge clk) begin
    if (step) begin
      q[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (step)   wr_ptr <= !wr_ptr;
      if (pop_ok) rd_ptr <= !rd_ptr;
      case ({step, pop_ok})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: src/led_driver_two_wire_frame_sender.sv
// Top level of the two-wire frame sender for a five-channel LED driver.
//
//   Channel   Handshake          Payload
//   input     push / full        opcode, five channel levels, sda_in
//   result    empty / pop        scl_drive_low, sda_drive_low, busy_res,
//                                frame_done, frame_ok, link_online
//   config    cfg_valid / ready  cfg_index, cfg_data
//
// Every accepted beat gives exactly one result beat, through the registered front queue and result queue.
// One beat per cycle is sustained; the front queue and the result queue hold two
// entries each, so a stalled result side fills them and then raises full.
// cfg_ready is always high. Reset is synchronous and empties both queues.
module led_driver_two_wire_frame_sender (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic [1:0]                        opcode,
  input  logic [7:0]                        red_level,
  input  logic [7:0]                        green_level,
  input  logic [7:0]                        blue_level,
  input  logic [7:0]                        cold_white_level,
  input  logic [7:0]                        warm_white_level,
  input  logic                              sda_in,
  output logic                              empty,
  input  logic                              pop,
  output logic                              scl_drive_low,
  output logic                              sda_drive_low,
  output logic                              busy_res,
  output logic                              frame_done,
  output logic                              frame_ok,
  output logic                              link_online,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ledfs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ledfs_pkg::CFG_DAT_W-1:0]   cfg_data
);

  logic               item_valid;
  logic               item_ready;
  ledfs_pkg::item_t   item;
  ledfs_pkg::result_t result;
  logic [15:0]        ack_timeout;

  assign cfg_ready = 1'b1;

  // Front end: registers, classification, frame build and the item queue.
  ledfs_front u_front (
    .clk              (clk),
    .rst              (rst),
    .push             (push),
    .full             (full),
    .opcode           (opcode),
    .red_level        (red_level),
    .green_level      (green_level),
    .blue_level       (blue_level),
    .cold_white_level (cold_white_level),
    .warm_white_level (warm_white_level),
    .sda_in           (sda_in),
    .cfg_write        (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .ack_timeout      (ack_timeout),
    .item_valid       (item_valid),
    .item_ready       (item_ready),
    .item             (item)
  );

  // Back end: bus phase sequencer and the result queue.
  ledfs_back u_back (
    .clk         (clk),
    .rst         (rst),
    .ack_timeout (ack_timeout),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .empty       (empty),
    .pop         (pop),
    .result      (result)
  );

  assign scl_drive_low = result.scl;
  assign sda_drive_low = result.sda;
  assign busy_res      = result.busy;
  assign frame_done    = result.done;
  assign frame_ok      = result.ok;
  assign link_online   = result.online;

endmodule

FILE: src/ledfs_checker.sv
// Port-level checker for the frame sender, bound to the top level.
module ledfs_checker (
  input logic clk,
  input logic rst,
  input logic full,
  input logic empty,
  input logic pop,
  input logic scl_drive_low,
  input logic sda_drive_low,
  input logic busy_res,
  input logic frame_done,
  input logic frame_ok,
  input logic link_online
);

  // A result beat that is not taken stays put.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(scl_drive_low) && $stable(sda_drive_low) &&
      $stable(busy_res) && $stable(frame_done) && $stable(frame_ok) &&
      $stable(link_online))
    else $error("result beat changed while stalled");

  // A good frame is only reported on its completion beat.
  a_ok_done: assert property (@(posedge clk) disable iff (rst)
    !empty && frame_ok |-> frame_done)
    else $error("frame_ok without frame_done");

  // Completion leaves the bus idle with both lines released.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    !empty && frame_done |-> !busy_res && !scl_drive_low && !sda_drive_low)
    else $error("frame_done while bus still driven");

  // The online flag follows the outcome of the frame that just finished.
  a_online: assert property (@(posedge clk) disable iff (rst)
    !empty && frame_done |-> link_online == frame_ok)
    else $error("link_online disagrees with frame outcome");

  // Right after reset the result queue is empty and the front queue is not full.
  a_reset: assert property (@(posedge clk)
    $past(rst) && !rst |-> empty && !full)
    else $error("queues not empty after reset");

endmodule

bind led_driver_two_wire_frame_sender ledfs_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .full          (full),
  .empty         (empty),
  .pop           (pop),
  .scl_drive_low (scl_drive_low),
  .sda_drive_low (sda_drive_low),
  .busy_res      (busy_res),
  .frame_done    (frame_done),
  .frame_ok      (frame_ok),
  .link_online   (link_online)
);
